[rtl/mva_pkg.sv]
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants of the MIDI voice allocator: sequencer states,
// result kinds, MIDI command nibbles and fixed limits.
// ----------------------------------------------------------------------------
package mva_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_ON_SCAN,
        ST_OFF_RD,
        ST_OFF_CMP,
        ST_FLUSH
    } state_t;

    // result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_VOICE_ON  = 2'd0;
    localparam kind_t KIND_VOICE_OFF = 2'd1;
    localparam kind_t KIND_CTRL      = 2'd2;
    localparam kind_t KIND_BEND      = 2'd3;

    // command nibbles of the running status
    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_NONE       = 4'h0;
    localparam cmd_t CMD_NOTE_OFF   = 4'h8;
    localparam cmd_t CMD_NOTE_ON    = 4'h9;
    localparam cmd_t CMD_KEY_PRESS  = 4'hA;
    localparam cmd_t CMD_CTRL       = 4'hB;
    localparam cmd_t CMD_PROGRAM    = 4'hC;
    localparam cmd_t CMD_CHAN_PRESS = 4'hD;
    localparam cmd_t CMD_BEND       = 4'hE;
    localparam cmd_t CMD_SYSTEM     = 4'hF;

    // fixed constants
    localparam logic [7:0]  CLOCK_BYTE  = 8'd248;
    localparam logic [13:0] BEND_CENTER = 14'd8192;
    localparam logic [3:0]  VC_RESET    = 4'd8;
    localparam int          MAX_RESULTS = 8;
    localparam int          EMIT_W      = $clog2(MAX_RESULTS + 1);

endpackage

[rtl/midi_voice_allocator_core.sv]
// ----------------------------------------------------------------------------
// midi_voice_allocator_core
// Parses a raw MIDI byte stream with running status, assigns voices
// round-robin on note-on, frees voices on note-off and reports controller
// changes and pitch bend as result items.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid / in_ready   | midi_byte
//  out      | output    | out_valid / out_ready | kind voice note value channel
//                                               | last
//  cfg      | input     | cfg_valid / cfg_ready | cfg_data (voice_count)
//
//  status, clock and ignored bytes are taken in idle; controller and bend
//  then pass the flush state. note-on: idle, start modulo, a scan of up to
//  n voices, then flush for the result. note-off: idle, then a note memory
//  read and a compare for each voice below the count, then flush for the
//  final result; output stalls hold the compare and flush states.
//  reset clears the voice valid bits at once; no clearing pass is needed.
//  in_ready is high only in idle; the output register lets the next byte in
//  while a result still waits.
module midi_voice_allocator_core #(
    parameter int NUM_VOICES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         midi_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [2:0]         voice,
    output logic [6:0]         note,
    output logic signed [13:0] value,
    output logic [3:0]         channel,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);

    localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W    = $clog2(NUM_VOICES + 1);
    localparam int WC       = (CNT_W > 4) ? CNT_W : 4;
    localparam int LV_RESET = ((NUM_VOICES < 8) ? NUM_VOICES : 8) - 1;

    // state
    mva_pkg::state_t                 state_reg, state_next;
    logic [3:0]                      voice_count_reg;
    mva_pkg::cmd_t                   rs_reg, rs_next;
    logic [3:0]                      ch_reg, ch_next;
    logic                            dc_reg, dc_next;
    logic [6:0]                      first_reg, first_next;
    logic [6:0]                      note_reg, note_next;
    logic [6:0]                      vel_reg, vel_next;
    logic [NUM_VOICES-1:0]           valid_reg, valid_next;
    logic [VIDX_W-1:0]               last_voice_reg, last_voice_next;
    logic [VIDX_W-1:0]               idx_reg, idx_next;
    logic [VIDX_W-1:0]               start_reg, start_next;
    logic [CNT_W-1:0]                modx_reg, modx_next;
    logic [mva_pkg::EMIT_W-1:0]      emit_cnt_reg, emit_cnt_next;
    mva_pkg::kind_t                  pend_kind_reg, pend_kind_next;
    logic [2:0]                      pend_voice_reg, pend_voice_next;
    logic [6:0]                      pend_note_reg, pend_note_next;
    logic [13:0]                     pend_value_reg, pend_value_next;

    // output register
    logic                            out_valid_reg;
    mva_pkg::kind_t                  kind_reg;
    logic [2:0]                      voice_reg;
    logic [6:0]                      note_out_reg;
    logic [13:0]                     value_reg;
    logic [3:0]                      channel_reg;
    logic                            last_reg;

    // note memory
    logic [6:0]                      note_mem [NUM_VOICES];
    logic [6:0]                      note_rd_reg;
    logic                            mem_we;

    // helpers
    logic                            can_push;
    logic                            push;
    logic                            push_last;
    logic [WC-1:0]                   vc_ext;
    logic [CNT_W-1:0]                eff_n;
    logic [CNT_W-1:0]                idx_inc;
    logic [VIDX_W-1:0]               idx_wrap;
    logic                            off_match;
    logic                            off_take;

    // effective voice count, saturated to 1..NUM_VOICES
    always_comb
    begin
        vc_ext = WC'(voice_count_reg);
        if (vc_ext == '0)
        begin
            eff_n = CNT_W'(1);
        end
        else if (vc_ext > WC'(NUM_VOICES))
        begin
            eff_n = CNT_W'(NUM_VOICES);
        end
        else
        begin
            eff_n = CNT_W'(vc_ext);
        end
    end

    // next voice index, wrapping at the count
    always_comb
    begin
        idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
        if (idx_inc >= eff_n)
        begin
            idx_wrap = '0;
        end
        else
        begin
            idx_wrap = VIDX_W'(idx_inc);
        end
    end

    assign can_push  = !out_valid_reg || out_ready;
    assign off_match = valid_reg[idx_reg] && (note_rd_reg == note_reg);
    assign off_take  = off_match && (emit_cnt_reg < mva_pkg::EMIT_W'(mva_pkg::MAX_RESULTS));

    // sequencer: next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        rs_next         = rs_reg;
        ch_next         = ch_reg;
        dc_next         = dc_reg;
        first_next      = first_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        valid_next      = valid_reg;
        last_voice_next = last_voice_reg;
        idx_next        = idx_reg;
        start_next      = start_reg;
        modx_next       = modx_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_kind_next  = pend_kind_reg;
        pend_voice_next = pend_voice_reg;
        pend_note_next  = pend_note_reg;
        pend_value_next = pend_value_reg;
        mem_we          = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;
        in_ready        = 1'b0;

        case (state_reg)
            mva_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (midi_byte == mva_pkg::CLOCK_BYTE)
                    begin
                        // timing clock is dropped
                    end
                    else if (midi_byte[7])
                    begin
                        rs_next = midi_byte[7:4];
                        ch_next = midi_byte[3:0];
                        dc_next = 1'b0;
                    end
                    else if (!rs_reg[3] || (rs_reg inside {mva_pkg::CMD_PROGRAM,
                             mva_pkg::CMD_CHAN_PRESS, mva_pkg::CMD_SYSTEM}))
                    begin
                        // data with no command or for a one-byte message
                    end
                    else if (!dc_reg)
                    begin
                        first_next = midi_byte[6:0];
                        dc_next    = 1'b1;
                    end
                    else
                    begin
                        dc_next   = 1'b0;
                        note_next = first_reg;
                        vel_next  = midi_byte[6:0];
                        case (rs_reg)
                            mva_pkg::CMD_NOTE_OFF, mva_pkg::CMD_NOTE_ON:
                            begin
                                if (rs_reg == mva_pkg::CMD_NOTE_ON && midi_byte[6:0] != 7'd0)
                                begin
                                    modx_next  = CNT_W'(last_voice_reg) + CNT_W'(1);
                                    state_next = mva_pkg::ST_MOD;
                                end
                                else
                                begin
                                    idx_next      = '0;
                                    emit_cnt_next = '0;
                                    state_next    = mva_pkg::ST_OFF_RD;
                                end
                            end
                            mva_pkg::CMD_CTRL:
                            begin
                                pend_kind_next  = mva_pkg::KIND_CTRL;
                                pend_voice_next = 3'd0;
                                pend_note_next  = first_reg;
                                pend_value_next = 14'(midi_byte[6:0]);
                                state_next      = mva_pkg::ST_FLUSH;
                            end
                            mva_pkg::CMD_BEND:
                            begin
                                pend_kind_next  = mva_pkg::KIND_BEND;
                                pend_voice_next = 3'd0;
                                pend_note_next  = 7'd0;
                                pend_value_next = {midi_byte[6:0], first_reg}
                                                  - mva_pkg::BEND_CENTER;
                                state_next      = mva_pkg::ST_FLUSH;
                            end
                            default:
                            begin
                                // key pressure is consumed silently
                            end
                        endcase
                    end
                end
            end

            // start = (last voice + 1) modulo count, by repeated subtraction
            mva_pkg::ST_MOD:
            begin
                if (modx_reg >= eff_n)
                begin
                    modx_next = modx_reg - eff_n;
                end
                else
                begin
                    idx_next   = VIDX_W'(modx_reg);
                    start_next = VIDX_W'(modx_reg);
                    state_next = mva_pkg::ST_ON_SCAN;
                end
            end

            // round-robin search for a free voice
            mva_pkg::ST_ON_SCAN:
            begin
                if (!valid_reg[idx_reg])
                begin
                    valid_next[idx_reg] = 1'b1;
                    mem_we              = 1'b1;
                    last_voice_next     = idx_reg;
                    pend_kind_next      = mva_pkg::KIND_VOICE_ON;
                    pend_voice_next     = 3'(idx_reg);
                    pend_note_next      = note_reg;
                    pend_value_next     = 14'(vel_reg);
                    state_next          = mva_pkg::ST_FLUSH;
                end
                else if (idx_wrap == start_reg)
                begin
                    state_next = mva_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_wrap;
                end
            end

            // note memory read in flight
            mva_pkg::ST_OFF_RD:
            begin
                state_next = mva_pkg::ST_OFF_CMP;
            end

            // compare one voice, hold back one result to mark the final one
            mva_pkg::ST_OFF_CMP:
            begin
                if (!(off_take && emit_cnt_reg != '0 && !can_push))
                begin
                    if (off_match)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (off_take)
                    begin
                        push            = (emit_cnt_reg != '0);
                        pend_kind_next  = mva_pkg::KIND_VOICE_OFF;
                        pend_voice_next = 3'(idx_reg);
                        pend_note_next  = note_reg;
                        pend_value_next = 14'(vel_reg);
                        emit_cnt_next   = emit_cnt_reg + mva_pkg::EMIT_W'(1);
                    end
                    if (CNT_W'(idx_reg) == eff_n - CNT_W'(1))
                    begin
                        if (off_take || emit_cnt_reg != '0)
                        begin
                            state_next = mva_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            state_next = mva_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = VIDX_W'(idx_inc);
                        state_next = mva_pkg::ST_OFF_RD;
                    end
                end
            end

            // hand the held result to the output as the final one
            mva_pkg::ST_FLUSH:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = mva_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mva_pkg::ST_IDLE;
            end
        endcase
    end

    // state register and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mva_pkg::ST_IDLE;
            voice_count_reg <= mva_pkg::VC_RESET;
            rs_reg          <= mva_pkg::CMD_NONE;
            ch_reg          <= 4'd0;
            dc_reg          <= 1'b0;
            first_reg       <= 7'd0;
            valid_reg       <= '0;
            last_voice_reg  <= VIDX_W'(LV_RESET);
            emit_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rs_reg         <= rs_next;
            ch_reg         <= ch_next;
            dc_reg         <= dc_next;
            first_reg      <= first_next;
            valid_reg      <= valid_next;
            last_voice_reg <= last_voice_next;
            emit_cnt_reg   <= emit_cnt_next;
            if (cfg_valid)
            begin
                voice_count_reg <= cfg_data;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        note_reg       <= note_next;
        vel_reg        <= vel_next;
        idx_reg        <= idx_next;
        start_reg      <= start_next;
        modx_reg       <= modx_next;
        pend_kind_reg  <= pend_kind_next;
        pend_voice_reg <= pend_voice_next;
        pend_note_reg  <= pend_note_next;
        pend_value_reg <= pend_value_next;
        if (push)
        begin
            kind_reg     <= pend_kind_reg;
            voice_reg    <= pend_voice_reg;
            note_out_reg <= pend_note_reg;
            value_reg    <= pend_value_reg;
            channel_reg  <= ch_reg;
            last_reg     <= push_last;
        end
    end

    // note memory, one write and one registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            note_mem[idx_reg] <= note_reg;
        end
        note_rd_reg <= note_mem[idx_reg];
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign voice     = voice_reg;
    assign note      = note_out_reg;
    assign value     = value_reg;
    assign channel   = channel_reg;
    assign last      = last_reg;

endmodule

[rtl/mva_checker.sv]
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks of the MIDI voice allocator result stream, bound to the
// top level.
// ----------------------------------------------------------------------------
module mva_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         kind,
    input logic [2:0]         voice,
    input logic [6:0]         note,
    input logic signed [13:0] value,
    input logic [3:0]         channel,
    input logic               last
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(voice)
            && $stable(note) && $stable(value) && $stable(channel) && $stable(last))
    else $error("stalled result item changed");

    // controller and bend items carry voice zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == mva_pkg::KIND_CTRL || kind == mva_pkg::KIND_BEND)
            |-> voice == 3'd0)
    else $error("nonzero voice on controller or bend item");

    // bend items carry note zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == mva_pkg::KIND_BEND |-> note == 7'd0)
    else $error("nonzero note on bend item");

    // voice events carry a 7-bit velocity, nonzero for voice on
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == mva_pkg::KIND_VOICE_ON || kind == mva_pkg::KIND_VOICE_OFF)
            |-> value[13:7] == 7'd0)
    else $error("voice event velocity out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == mva_pkg::KIND_VOICE_ON |-> value != 14'sd0 && last)
    else $error("voice on item with zero velocity or not final");

endmodule

bind midi_voice_allocator_core mva_checker u_mva_checker (.*);
